FILE: rtl/lfcs_pkg.sv
`timescale 1ns / 1ps

package lfcs_pkg;

   // Field widths of one item on each channel.
   localparam int OP_W       = 2;
   localparam int COORD_W    = 4;
   localparam int LED_IDX_W  = 7;
   localparam int STEP_W     = 8;
   localparam int COLOR_W    = 8;
   localparam int PIXEL_W    = 3 * COLOR_W;
   localparam int LEVEL_W    = 5;
   localparam int NUM_W      = 2 * COLOR_W;

   // Width of a mapped write position: row up to 15 times width up to 64, plus 63.
   localparam int POS_W      = 10;
   // Width used for range compares against the pixel count (up to 4096).
   localparam int CMP_W      = 13;

   localparam logic [LEVEL_W-1:0] BRIGHT_RESET      = 5'd16;
   localparam logic [PIXEL_W-1:0] FIRST_PIXEL_RESET = 24'hFFFF00;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE  = 2'd0,
      OP_FILL   = 2'd1,
      OP_READ   = 2'd2,
      OP_COMMIT = 2'd3
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]      operation;
      logic [COORD_W-1:0]   column;
      logic [COORD_W-1:0]   row;
      logic [LED_IDX_W-1:0] led_index;
      logic [STEP_W-1:0]    fade_step;
      logic [COLOR_W-1:0]   in_red;
      logic [COLOR_W-1:0]   in_green;
      logic [COLOR_W-1:0]   in_blue;
   } req_item_type;

   typedef struct packed {
      logic [COLOR_W-1:0] out_red;
      logic [COLOR_W-1:0] out_green;
      logic [COLOR_W-1:0] out_blue;
      logic               lit;
      logic [LEVEL_W-1:0] level;
   } rsp_item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;      // capture the request item, clear the sweep counter
      logic write_px;   // store one pixel into the new frame
      logic fill;       // write the fill colour at the sweep counter
      logic clear;      // write reset contents at the sweep counter
      logic copy_rd;    // read the new frame at the sweep counter for a commit
      logic mult;       // register the blend products
      logic load_out;   // load the result register
      logic cnt_inc;    // advance the sweep counter
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cnt_last;   // sweep counter sits on the last pixel
      logic out_free;   // result register can take a new item this cycle
   } status_type;

endpackage

FILE: rtl/lfcs_channels.sv
`timescale 1ns / 1ps

// Request channel: one operation per item.
interface lfcs_req_if;
   import lfcs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      operation;
   logic [COORD_W-1:0]   column;
   logic [COORD_W-1:0]   row;
   logic [LED_IDX_W-1:0] led_index;
   logic [STEP_W-1:0]    fade_step;
   logic [COLOR_W-1:0]   in_red;
   logic [COLOR_W-1:0]   in_green;
   logic [COLOR_W-1:0]   in_blue;

   modport source (
      output valid, operation, column, row, led_index, fade_step, in_red, in_green, in_blue,
      input  ready
   );
   modport sink (
      input  valid, operation, column, row, led_index, fade_step, in_red, in_green, in_blue,
      output ready
   );
endinterface

// Response channel: one result item per request item.
interface lfcs_rsp_if;
   import lfcs_pkg::*;

   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] out_red;
   logic [COLOR_W-1:0] out_green;
   logic [COLOR_W-1:0] out_blue;
   logic               lit;
   logic [LEVEL_W-1:0] level;

   modport source (
      output valid, out_red, out_green, out_blue, lit, level,
      input  ready
   );
   modport sink (
      input  valid, out_red, out_green, out_blue, lit, level,
      output ready
   );
endinterface

// Brightness register write channel.
interface lfcs_csr_if;
   import lfcs_pkg::*;

   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] data;

   modport source (
      output valid, data,
      input  ready
   );
   modport sink (
      input  valid, data,
      output ready
   );
endinterface

FILE: rtl/lfcs_datapath.sv
`timescale 1ns / 1ps

module lfcs_datapath #(
   parameter int MATRIX_WIDTH  = 11,
   parameter int MATRIX_HEIGHT = 10,
   parameter int PIXEL_COUNT   = 110
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lfcs_pkg::cmd_type     cmd,
   output lfcs_pkg::status_type  status,
   input  lfcs_pkg::req_item_type req_item,
   input  logic                  csr_we,
   input  logic [lfcs_pkg::LEVEL_W-1:0] csr_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output lfcs_pkg::rsp_item_type rsp_item
);
   import lfcs_pkg::*;

   localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

   // Rounded division by 255 for values up to 255*255, half up.
   function automatic logic [COLOR_W-1:0] div255_round(input logic [NUM_W-1:0] num);
      logic [NUM_W-1:0] t;
      logic [NUM_W:0]   acc;
      t   = num + NUM_W'(127);
      acc = {1'b0, t} + (NUM_W + 1)'(t[NUM_W-1:COLOR_W]) + (NUM_W + 1)'(1);
      return acc[NUM_W-1:COLOR_W];
   endfunction

   req_item_type item_ff;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [LEVEL_W-1:0] bright_ff;
   logic copy_wr_ff;
   logic [ADDR_W-1:0] copy_addr_ff;

   logic [PIXEL_W-1:0] shown_mem [PIXEL_COUNT];
   logic [PIXEL_W-1:0] target_mem [PIXEL_COUNT];
   logic [PIXEL_W-1:0] shown_rd_ff;
   logic [PIXEL_W-1:0] target_rd_ff;

   logic [NUM_W-1:0] num_ff [3];
   logic [NUM_W-1:0] num_in [3];
   logic             lit_ff;

   logic               rsp_valid_ff;
   rsp_item_type       rsp_ff;

   logic [PIXEL_W-1:0] colour;
   logic [POS_W-1:0]   pos_x;
   logic [POS_W-1:0]   pos;
   logic               pos_ok;
   logic               idx_ok;
   logic               read_hit;
   logic [ADDR_W-1:0]  idx_addr;

   logic               tgt_we;
   logic [ADDR_W-1:0]  tgt_wa;
   logic [PIXEL_W-1:0] tgt_wd;
   logic [ADDR_W-1:0]  tgt_ra;
   logic               shn_we;
   logic [ADDR_W-1:0]  shn_wa;
   logic [PIXEL_W-1:0] shn_wd;

   // Request capture and brightness register.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= BRIGHT_RESET;
      end else if (csr_we) begin
         bright_ff <= csr_data;
      end
   end

   // Sweep counter for the clearing pass, fill and commit.
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.latch) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = status.cnt_last ? '0 : cnt_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign status.cnt_last = (cnt_ff == ADDR_W'(PIXEL_COUNT - 1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Serpentine mapping of a pixel write: odd rows run right to left.
   assign colour = {item_ff.in_red, item_ff.in_green, item_ff.in_blue};
   assign pos_x  = item_ff.row[0] ? POS_W'(MATRIX_WIDTH - 1) - POS_W'(item_ff.column)
                                  : POS_W'(item_ff.column);
   assign pos    = POS_W'(item_ff.row) * POS_W'(MATRIX_WIDTH) + pos_x;
   assign pos_ok = (CMP_W'(item_ff.column) < CMP_W'(MATRIX_WIDTH))
                && (CMP_W'(item_ff.row) < CMP_W'(MATRIX_HEIGHT))
                && (CMP_W'(pos) < CMP_W'(PIXEL_COUNT));

   assign idx_ok   = CMP_W'(item_ff.led_index) < CMP_W'(PIXEL_COUNT);
   assign idx_addr = ADDR_W'(item_ff.led_index);
   assign read_hit = (item_ff.operation == OP_READ) && idx_ok;

   // New frame port selection.
   always_comb begin
      tgt_we = cmd.fill || cmd.clear || (cmd.write_px && pos_ok);
      tgt_wa = cmd.write_px ? ADDR_W'(pos) : cnt_ff;
      tgt_wd = cmd.clear ? '0 : colour;
      tgt_ra = cmd.copy_rd ? cnt_ff : idx_addr;
   end

   // Old frame port selection: reset contents or the commit copy.
   always_comb begin
      shn_we = cmd.clear || copy_wr_ff;
      shn_wa = cmd.clear ? cnt_ff : copy_addr_ff;
      if (cmd.clear) begin
         shn_wd = (cnt_ff == '0) ? FIRST_PIXEL_RESET : '0;
      end else begin
         shn_wd = target_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tgt_we) begin
         target_mem[tgt_wa] <= tgt_wd;
      end
      target_rd_ff <= target_mem[tgt_ra];
   end

   always_ff @(posedge clock) begin
      if (shn_we) begin
         shown_mem[shn_wa] <= shn_wd;
      end
      shown_rd_ff <= shown_mem[idx_addr];
   end

   // Commit copy writes the old frame in the cycle after its read of the new frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         copy_wr_ff <= 1'b0;
      end else begin
         copy_wr_ff <= cmd.copy_rd;
      end
   end

   always_ff @(posedge clock) begin
      copy_addr_ff <= cnt_ff;
   end

   // Blend products: old weighted by 255-s plus new weighted by s, per channel.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         num_in[c] = NUM_W'(shown_rd_ff[c*COLOR_W +: COLOR_W])
                        * NUM_W'(8'd255 - item_ff.fade_step)
                   + NUM_W'(target_rd_ff[c*COLOR_W +: COLOR_W])
                        * NUM_W'(item_ff.fade_step);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         for (int c = 0; c < 3; c++) begin
            num_ff[c] <= num_in[c];
         end
         lit_ff <= (target_rd_ff != '0);
      end
   end

   // Result register; it takes a new item when empty or being drained.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.level <= bright_ff;
         if (read_hit) begin
            rsp_ff.out_red   <= div255_round(num_ff[2]);
            rsp_ff.out_green <= div255_round(num_ff[1]);
            rsp_ff.out_blue  <= div255_round(num_ff[0]);
            rsp_ff.lit       <= lit_ff;
         end else begin
            rsp_ff.out_red   <= '0;
            rsp_ff.out_green <= '0;
            rsp_ff.out_blue  <= '0;
            rsp_ff.lit       <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

FILE: rtl/lfcs_ctrl.sv
`timescale 1ns / 1ps

module lfcs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [lfcs_pkg::OP_W-1:0] req_operation,
   output logic                      req_ready,
   input  lfcs_pkg::status_type      status,
   output lfcs_pkg::cmd_type         cmd
);
   import lfcs_pkg::*;

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_WRITE  = 9'b000000100,
      ST_FILL   = 9'b000001000,
      ST_COMMIT = 9'b000010000,
      ST_FLUSH  = 9'b000100000,
      ST_READ   = 9'b001000000,
      ST_MULT   = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear   = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               case (op_type'(req_operation))
                  OP_WRITE:  state_in = ST_WRITE;
                  OP_FILL:   state_in = ST_FILL;
                  OP_READ:   state_in = ST_READ;
                  OP_COMMIT: state_in = ST_COMMIT;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_WRITE: begin
            cmd.write_px = 1'b1;
            state_in     = ST_DONE;
         end
         ST_FILL: begin
            cmd.fill    = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_DONE;
            end
         end
         ST_COMMIT: begin
            cmd.copy_rd = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // The last copied pixel is written during this cycle.
            state_in = ST_DONE;
         end
         ST_READ: begin
            state_in = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/led_frame_crossfade_store_top.sv
`timescale 1ns / 1ps

// Frame store for a serpentine LED matrix with a crossfade between an old and a new frame.
// The req_bus channel takes one operation per item: pixel write, fill of the new frame,
// blended read at a strip index, or commit of the new frame to the old one. Every item
// gives exactly one item on rsp_bus; only a read carries a color and a lit flag, and
// every result carries the brightness level. csr_bus writes the brightness and is
// always ready.
// From accept, a write passes WRITE and DONE, a read READ, MULT and DONE, a fill FILL
// and DONE, and a commit COMMIT, FLUSH and DONE; the result is loaded in DONE, and the
// next item can be taken in IDLE after that. Fill and commit step the sweep counter
// through one pixel per cycle on the single write port of each frame memory.
// After reset a clearing pass over every pixel writes the reset frames; no item
// is taken during it. A stalled receiver does not block the next request: the result
// register holds its item, and a later result waits in the datapath until that
// register is drained.
module led_frame_crossfade_store_top #(
   parameter int MATRIX_WIDTH  = 11,
   parameter int MATRIX_HEIGHT = 10,
   parameter int PIXEL_COUNT   = 110
) (
   input logic        clock,
   input logic        reset,
   lfcs_req_if.sink   req_bus,
   lfcs_rsp_if.source rsp_bus,
   lfcs_csr_if.sink   csr_bus
);
   import lfcs_pkg::*;

   cmd_type      cmd;
   status_type   status;
   req_item_type req_item;
   rsp_item_type rsp_item;
   logic         rsp_valid;
   logic         req_ready;

   // Pack the request payload.
   assign req_item.operation = req_bus.operation;
   assign req_item.column    = req_bus.column;
   assign req_item.row       = req_bus.row;
   assign req_item.led_index = req_bus.led_index;
   assign req_item.fade_step = req_bus.fade_step;
   assign req_item.in_red    = req_bus.in_red;
   assign req_item.in_green  = req_bus.in_green;
   assign req_item.in_blue   = req_bus.in_blue;
   assign req_bus.ready      = req_ready;

   assign csr_bus.ready = 1'b1;

   lfcs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.operation),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   lfcs_datapath #(
      .MATRIX_WIDTH  (MATRIX_WIDTH),
      .MATRIX_HEIGHT (MATRIX_HEIGHT),
      .PIXEL_COUNT   (PIXEL_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .csr_we    (csr_bus.valid),
      .csr_data  (csr_bus.data),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Unpack the result payload.
   assign rsp_bus.valid     = rsp_valid;
   assign rsp_bus.out_red   = rsp_item.out_red;
   assign rsp_bus.out_green = rsp_item.out_green;
   assign rsp_bus.out_blue  = rsp_item.out_blue;
   assign rsp_bus.lit       = rsp_item.lit;
   assign rsp_bus.level     = rsp_item.level;

endmodule

FILE: tb/sv/led_frame_crossfade_store_top_test.sv
`timescale 1ns / 1ps

module led_frame_crossfade_store_top_test;
   import lfcs_pkg::*;

   localparam int MATRIX_WIDTH  = 11;
   localparam int MATRIX_HEIGHT = 10;
   localparam int PIXEL_COUNT   = 110;
   localparam int FULL_STEP     = 255;
   localparam int IDLE_PCT      = 27;
   localparam int PHASE_ITEMS   = 250;
   localparam int PHASE_COUNT   = 8;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 400;
   localparam longint RUN_LIMIT_NS = 64'd20_000_000;

   logic clock;
   logic reset;

   lfcs_req_if req_bus ();
   lfcs_rsp_if rsp_bus ();
   lfcs_csr_if csr_bus ();

   led_frame_crossfade_store_top #(
      .MATRIX_WIDTH  (MATRIX_WIDTH),
      .MATRIX_HEIGHT (MATRIX_HEIGHT),
      .PIXEL_COUNT   (PIXEL_COUNT)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Predicted contents of both frames and the brightness register.
   logic [PIXEL_W-1:0] shown_px [PIXEL_COUNT];
   logic [PIXEL_W-1:0] target_px [PIXEL_COUNT];
   logic [LEVEL_W-1:0] level_now;

   req_item_type queued_ops [$];
   rsp_item_type awaited_results [$];
   int mismatch_count;

   logic req_fire;
   logic steady;
   logic hold_go;
   logic rsp_hold;

   req_item_type next_req;
   req_item_type seen_req;
   rsp_item_type seen_rsp;
   rsp_item_type want_rsp;

   // Clock generation.
   initial begin
      clock = 1'b0;
   end
   always begin
      #5 clock = ~clock;
   end

   // Rounded blend of one color channel between the old and new frame.
   function automatic logic [COLOR_W-1:0] blend_channel(input int old_c, input int new_c,
                                                        input int fade);
      int num;
      num = old_c * (FULL_STEP - fade) + new_c * fade;
      return COLOR_W'((2 * num + FULL_STEP) / (2 * FULL_STEP));
   endfunction

   // Apply one operation to the predicted frames and return the result it gives.
   function automatic rsp_item_type predict_pixel_result(input req_item_type op);
      rsp_item_type res;
      logic [PIXEL_W-1:0] color;
      logic [PIXEL_W-1:0] old_px;
      logic [PIXEL_W-1:0] new_px;
      int xo;
      int pos;
      int fade;
      res = '0;
      color = {op.in_red, op.in_green, op.in_blue};
      fade = int'(op.fade_step);
      case (op_type'(op.operation))
         OP_WRITE: begin
            // Odd rows run right to left along the strip.
            if (int'(op.column) < MATRIX_WIDTH && int'(op.row) < MATRIX_HEIGHT) begin
               xo = op.row[0] ? (MATRIX_WIDTH - 1 - int'(op.column)) : int'(op.column);
               pos = int'(op.row) * MATRIX_WIDTH + xo;
               if (pos < PIXEL_COUNT) begin
                  target_px[LED_IDX_W'(pos)] = color;
               end
            end
         end
         OP_FILL: begin
            foreach (target_px[i]) begin
               target_px[i] = color;
            end
         end
         OP_READ: begin
            if (int'(op.led_index) < PIXEL_COUNT) begin
               old_px = shown_px[op.led_index];
               new_px = target_px[op.led_index];
               res.out_red   = blend_channel(int'(old_px[23:16]), int'(new_px[23:16]), fade);
               res.out_green = blend_channel(int'(old_px[15:8]), int'(new_px[15:8]), fade);
               res.out_blue  = blend_channel(int'(old_px[7:0]), int'(new_px[7:0]), fade);
               res.lit       = (new_px != '0);
            end
         end
         default: begin
            foreach (shown_px[i]) begin
               shown_px[i] = target_px[i];
            end
         end
      endcase
      res.level = level_now;
      return res;
   endfunction

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_op(input op_type kind, input int col, input int row, input int idx,
                           input int fade, input int red, input int green, input int blue);
      req_item_type op;
      op.operation = kind;
      op.column    = COORD_W'(col);
      op.row       = COORD_W'(row);
      op.led_index = LED_IDX_W'(idx);
      op.fade_step = STEP_W'(fade);
      op.in_red    = COLOR_W'(red);
      op.in_green  = COLOR_W'(green);
      op.in_blue   = COLOR_W'(blue);
      queued_ops.push_back(op);
   endtask

   // Mostly well-formed writes and reads, some fills and commits, with a share of off-matrix coordinates and indices.
   function automatic req_item_type random_op();
      req_item_type op;
      int pick;
      int fade_pick;
      op.column    = COORD_W'($urandom_range(15));
      op.row       = COORD_W'($urandom_range(15));
      op.led_index = LED_IDX_W'($urandom_range(127));
      op.in_red    = COLOR_W'($urandom_range(255));
      op.in_green  = COLOR_W'($urandom_range(255));
      op.in_blue   = COLOR_W'($urandom_range(255));
      fade_pick = $urandom_range(9);
      if (fade_pick == 0) begin
         op.fade_step = '0;
      end else if (fade_pick == 1) begin
         op.fade_step = STEP_W'(FULL_STEP);
      end else begin
         op.fade_step = STEP_W'($urandom_range(255));
      end
      // Black pixels now and then so that the lit flag goes both ways.
      if ($urandom_range(9) == 0) begin
         op.in_red   = '0;
         op.in_green = '0;
         op.in_blue  = '0;
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
         op.operation = OP_WRITE;
         if ($urandom_range(99) >= 8) begin
            op.column = COORD_W'($urandom_range(MATRIX_WIDTH - 1));
            op.row    = COORD_W'($urandom_range(MATRIX_HEIGHT - 1));
         end
      end else if (pick < 82) begin
         op.operation = OP_READ;
         if ($urandom_range(99) >= 8) begin
            op.led_index = LED_IDX_W'($urandom_range(PIXEL_COUNT - 1));
         end
      end else if (pick < 88) begin
         op.operation = OP_FILL;
      end else begin
         op.operation = OP_COMMIT;
      end
      return op;
   endfunction

   // Wait until every queued item was taken and every result came back.
   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (queued_ops.size() != 0 || awaited_results.size() != 0 || req_bus.valid);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the brightness register while the block is idle.
   task automatic write_brightness(input logic [LEVEL_W-1:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.data  = value;
      do begin
         @(posedge clock);
      end while (!csr_bus.ready);
      level_now = value;
      @(negedge clock);
      csr_bus.valid = 1'b0;
      @(posedge clock);
   endtask

   // Driver: present the next queued item once the current one is taken.
   always @(negedge clock) begin
      if (!reset && (!req_bus.valid || req_fire)) begin
         if (queued_ops.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            next_req = queued_ops.pop_front();
            req_bus.operation <= next_req.operation;
            req_bus.column    <= next_req.column;
            req_bus.row       <= next_req.row;
            req_bus.led_index <= next_req.led_index;
            req_bus.fade_step <= next_req.fade_step;
            req_bus.in_red    <= next_req.in_red;
            req_bus.in_green  <= next_req.in_green;
            req_bus.in_blue   <= next_req.in_blue;
            req_bus.valid     <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, none in the steady phase, stalled throughout while held off.
   always @(negedge clock) begin
      rsp_bus.ready <= !rsp_hold && (steady || $urandom_range(99) >= IDLE_PCT);
   end

   // Long hold-off of the receiver, counted here while the sender keeps going.
   initial begin
      rsp_hold = 1'b0;
      wait (hold_go);
      @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   // Monitor: check each result against the oldest prediction, then predict new items.
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_rsp.out_red   = rsp_bus.out_red;
            seen_rsp.out_green = rsp_bus.out_green;
            seen_rsp.out_blue  = rsp_bus.out_blue;
            seen_rsp.lit       = rsp_bus.lit;
            seen_rsp.level     = rsp_bus.level;
            if (awaited_results.size() == 0) begin
               report_mismatch("result with no item outstanding", 1, 0);
            end else begin
               want_rsp = awaited_results.pop_front();
               if (seen_rsp.out_red !== want_rsp.out_red) begin
                  report_mismatch("out_red", int'(seen_rsp.out_red),
                                  int'(want_rsp.out_red));
               end
               if (seen_rsp.out_green !== want_rsp.out_green) begin
                  report_mismatch("out_green", int'(seen_rsp.out_green),
                                  int'(want_rsp.out_green));
               end
               if (seen_rsp.out_blue !== want_rsp.out_blue) begin
                  report_mismatch("out_blue", int'(seen_rsp.out_blue),
                                  int'(want_rsp.out_blue));
               end
               if (seen_rsp.lit !== want_rsp.lit) begin
                  report_mismatch("lit", int'(seen_rsp.lit), int'(want_rsp.lit));
               end
               if (seen_rsp.level !== want_rsp.level) begin
                  report_mismatch("level", int'(seen_rsp.level), int'(want_rsp.level));
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen_req.operation = req_bus.operation;
            seen_req.column    = req_bus.column;
            seen_req.row       = req_bus.row;
            seen_req.led_index = req_bus.led_index;
            seen_req.fade_step = req_bus.fade_step;
            seen_req.in_red    = req_bus.in_red;
            seen_req.in_green  = req_bus.in_green;
            seen_req.in_blue   = req_bus.in_blue;
            awaited_results.push_back(predict_pixel_result(seen_req));
         end
         req_fire <= req_bus.valid && req_bus.ready;
      end
   end

   // Run limit.
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAIL");
      $finish;
   end

   // Stimulus: reset, a directed pass, then random phases at several brightness levels.
   initial begin
      logic [LEVEL_W-1:0] levels [PHASE_COUNT];
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.operation = '0;
      req_bus.column = '0;
      req_bus.row = '0;
      req_bus.led_index = '0;
      req_bus.fade_step = '0;
      req_bus.in_red = '0;
      req_bus.in_green = '0;
      req_bus.in_blue = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      steady = 1'b0;
      hold_go = 1'b0;
      mismatch_count = 0;
      level_now = BRIGHT_RESET;
      foreach (shown_px[i]) begin
         shown_px[i] = '0;
         target_px[i] = '0;
      end
      shown_px[0] = FIRST_PIXEL_RESET;
      levels = '{5'd31, 5'd0, 5'd0, 5'd1, 5'd30, 5'd0, 5'd15, 5'd0};
      levels[2] = LEVEL_W'($urandom_range(31));
      levels[5] = LEVEL_W'($urandom_range(31));
      levels[7] = LEVEL_W'($urandom_range(31));

      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // Reset frames, both fade extremes, and reads past the strip end.
      queue_op(OP_READ, 0, 0, 0, 0, 0, 0, 0);
      queue_op(OP_READ, 0, 0, 0, FULL_STEP, 0, 0, 0);
      queue_op(OP_READ, 15, 15, 0, 128, 255, 255, 255);
      queue_op(OP_READ, 0, 0, 127, 100, 0, 0, 0);
      queue_op(OP_READ, 0, 0, PIXEL_COUNT, 255, 0, 0, 0);
      // Writes on even and odd rows, at the corners, and off the matrix.
      queue_op(OP_WRITE, 0, 0, 0, 0, 255, 255, 255);
      queue_op(OP_WRITE, 10, 1, 0, 0, 8'h12, 8'h34, 8'h56);
      queue_op(OP_WRITE, 0, 1, 0, 0, 8'h01, 8'h02, 8'h03);
      queue_op(OP_WRITE, 0, 9, 127, 255, 8'hA5, 8'h5A, 8'hFF);
      queue_op(OP_WRITE, 11, 0, 0, 0, 8'h77, 8'h77, 8'h77);
      queue_op(OP_WRITE, 15, 15, 0, 0, 8'h66, 8'h66, 8'h66);
      queue_op(OP_WRITE, 0, 10, 0, 0, 8'h55, 8'h55, 8'h55);
      queue_op(OP_READ, 0, 0, 11, FULL_STEP, 0, 0, 0);
      queue_op(OP_READ, 0, 0, 21, FULL_STEP, 0, 0, 0);
      queue_op(OP_READ, 0, 0, PIXEL_COUNT - 1, FULL_STEP, 0, 0, 0);
      queue_op(OP_READ, 0, 0, 0, 77, 0, 0, 0);
      // Commit, then fills with a color and with black.
      queue_op(OP_COMMIT, 0, 0, 0, 0, 0, 0, 0);
      queue_op(OP_READ, 0, 0, 0, 77, 0, 0, 0);
      queue_op(OP_FILL, 0, 0, 0, 0, 8'h80, 8'h40, 8'h01);
      queue_op(OP_READ, 0, 0, 5, 1, 0, 0, 0);
      queue_op(OP_READ, 0, 0, PIXEL_COUNT - 1, 254, 0, 0, 0);
      queue_op(OP_COMMIT, 0, 0, 0, 0, 0, 0, 0);
      queue_op(OP_FILL, 0, 0, 0, 0, 0, 0, 0);
      queue_op(OP_READ, 0, 0, 50, 200, 0, 0, 0);
      queue_op(OP_READ, 0, 0, 11, 0, 0, 0, 0);
      wait_drained();

      // Random phases; one without idling and one with the receiver held off.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_brightness(levels[p]);
         steady = (p == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            queued_ops.push_back(random_op());
         end
         if (p == 4) begin
            hold_go = 1'b1;
         end
         wait_drained();
      end
      steady = 1'b0;

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
